// ===== design/rhsl_pkg.sv =====
// shared types and constants for the rgb to hsl converter
package rhsl_pkg;

  // channel and result widths
  localparam int unsigned ChanW  = 8;
  localparam int unsigned SumW   = 9;
  localparam int unsigned HueW   = 15;

  // one quotient bit per divider cell
  localparam int unsigned NumCells = 12;
  localparam int unsigned DivW     = 20;

  // hue scale in 1/64 degree
  localparam logic [HueW-1:0] HueGreenOff = 15'd7680;
  localparam logic [HueW-1:0] HueBlueOff  = 15'd15360;
  localparam logic [HueW-1:0] HueFull     = 15'd23040;
  localparam logic [SumW-1:0] ChanMax     = 9'd255;
  localparam logic [SumW-1:0] SumMax      = 9'd510;

  // which channel holds the max
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // data that rides along the divider chain untouched
  typedef struct packed {
    logic              grey;
    logic              neg;
    sector_e           sector;
    logic [SumW-1:0]   sum;
    logic [ChanW-1:0]  alpha;
  } rhsl_side_t;

  // working set of one pixel inside the divider chain
  typedef struct packed {
    logic [DivW-1:0]     rem_h;
    logic [DivW-1:0]     dv_h;
    logic [NumCells-1:0] q_h;
    logic [DivW-1:0]     rem_s;
    logic [DivW-1:0]     dv_s;
    logic [NumCells-1:0] q_s;
    rhsl_side_t          side;
  } rhsl_work_t;

endpackage

// ===== design/rhsl_prep.sv =====
// front stage: max, min, sum, sector and divider operands
module rhsl_prep import rhsl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  input  logic [ChanW-1:0] alpha_i,
  output logic             stall_o,
  output logic             valid_o,
  output rhsl_work_t       work_o,
  input  logic             stall_i
);

  logic [ChanW-1:0] hi, lo, delta, mag;
  logic [SumW-1:0]  sum, den;
  logic signed [ChanW:0] diff;
  sector_e          sector;
  rhsl_work_t       work_d, work_q;
  logic             valid_q;

  // max and min of the three channels
  always_comb begin
    hi = (red_i > green_i) ? red_i : green_i;
    hi = (hi > blue_i) ? hi : blue_i;
    lo = (red_i < green_i) ? red_i : green_i;
    lo = (lo < blue_i) ? lo : blue_i;
  end

  assign sum   = {1'b0, hi} + {1'b0, lo};
  assign delta = hi - lo;
  assign den   = (sum <= ChanMax) ? sum : (SumMax - sum);

  // sector pick, red first then green
  always_comb begin
    if (red_i == hi) begin
      sector = SEC_RED;
      diff   = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i == hi) begin
      sector = SEC_GREEN;
      diff   = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sector = SEC_BLUE;
      diff   = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  assign mag = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];

  // operands: 3840*|diff| over delta, 255*delta over den, divisors pre-shifted
  always_comb begin
    work_d.rem_h       = ({12'd0, mag} << 12) - ({12'd0, mag} << 8);
    work_d.dv_h        = {1'b0, delta, 11'd0};
    work_d.q_h         = '0;
    work_d.rem_s       = ({12'd0, delta} << 8) - {12'd0, delta};
    work_d.dv_s        = {den, 11'd0};
    work_d.q_s         = '0;
    work_d.side.grey   = (hi == lo);
    work_d.side.neg    = diff[ChanW];
    work_d.side.sector = sector;
    work_d.side.sum    = sum;
    work_d.side.alpha  = alpha_i;
  end

  assign stall_o = valid_q && stall_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// ===== design/rhsl_cell.sv =====
// divider cell: one restoring quotient bit for hue and saturation
module rhsl_cell import rhsl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  rhsl_work_t work_i,
  output logic       stall_o,
  output logic       valid_o,
  output rhsl_work_t work_o,
  input  logic       stall_i
);

  rhsl_work_t work_d, work_q;
  logic       valid_q;
  logic       take_h, take_s;

  // trial subtract on both dividers, then shift the divisors down
  always_comb begin
    take_h       = (work_i.rem_h >= work_i.dv_h);
    take_s       = (work_i.rem_s >= work_i.dv_s);
    work_d       = work_i;
    work_d.rem_h = take_h ? (work_i.rem_h - work_i.dv_h) : work_i.rem_h;
    work_d.rem_s = take_s ? (work_i.rem_s - work_i.dv_s) : work_i.rem_s;
    work_d.q_h   = {work_i.q_h[NumCells-2:0], take_h};
    work_d.q_s   = {work_i.q_s[NumCells-2:0], take_s};
    work_d.dv_h  = work_i.dv_h >> 1;
    work_d.dv_s  = work_i.dv_s >> 1;
  end

  assign stall_o = valid_q && stall_i;

  // cell valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  // cell payload
  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// ===== design/rhsl_post.sv =====
// output stage: hue offset and wrap, grey override, result register
module rhsl_post import rhsl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  rhsl_work_t       work_i,
  output logic             stall_o,
  output logic             valid_o,
  output logic [HueW-1:0]  hue_o,
  output logic [ChanW-1:0] sat_o,
  output logic [SumW-1:0]  light_o,
  output logic [ChanW-1:0] alpha_o,
  input  logic             stall_i
);

  logic [HueW-1:0]  qh, off, hue_d, hue_q;
  logic [ChanW-1:0] sat_d, sat_q, alpha_q;
  logic [SumW-1:0]  light_q;
  logic             valid_q;

  assign qh = {{(HueW-NumCells){1'b0}}, work_i.q_h};

  // sector offset
  always_comb begin
    case (work_i.side.sector)
      SEC_RED:   off = '0;
      SEC_GREEN: off = HueGreenOff;
      SEC_BLUE:  off = HueBlueOff;
      default:   off = '0;
    endcase
  end

  // add or subtract the quotient by its sign, wrap below zero; grey forces hue and saturation to zero
  always_comb begin
    if (work_i.side.grey) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      sat_d = work_i.q_s[ChanW-1:0];
      if (!work_i.side.neg) begin
        hue_d = off + qh;
      end else if (work_i.side.sector == SEC_RED) begin
        hue_d = (qh == '0) ? '0 : (HueFull - qh);
      end else begin
        hue_d = off - qh;
      end
    end
  end

  assign stall_o = valid_q && stall_i;

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      light_q <= work_i.side.sum;
      alpha_q <= work_i.side.alpha;
    end
  end

  assign valid_o = valid_q;
  assign hue_o   = hue_q;
  assign sat_o   = sat_q;
  assign light_o = light_q;
  assign alpha_o = alpha_q;

endmodule

// ===== design/rgb_to_hsl_converter_core.sv =====
// top level of the rgb to hsl converter: front stage, divider cell row, output stage
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------
//   in      | sink      | in_valid_i / in_stall_o | red_in, green_in, blue_in, alpha_in
//   out     | source    | out_valid_o / out_stall_i | hue_out, sat_out, light_sum, alpha_out
//
// one pixel per clock sustained while the output is not stalled; each transaction
// passes through one front stage, twelve divider cells (one quotient bit each)
// and the output register.
// reset clears only the stage valid bits.
// a stall holds the output register; stages further back keep filling bubbles,
// so the input stalls only once every stage holds a pixel.
module rgb_to_hsl_converter_core import rhsl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ChanW-1:0] red_in_i,
  input  logic [ChanW-1:0] green_in_i,
  input  logic [ChanW-1:0] blue_in_i,
  input  logic [ChanW-1:0] alpha_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [HueW-1:0]  hue_out_o,
  output logic [ChanW-1:0] sat_out_o,
  output logic [SumW-1:0]  light_sum_o,
  output logic [ChanW-1:0] alpha_out_o
);

  rhsl_work_t work  [NumCells+1];
  logic       valid [NumCells+1];
  logic       stall [NumCells+1];

  // operand setup
  rhsl_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .red_i   (red_in_i),
    .green_i (green_in_i),
    .blue_i  (blue_in_i),
    .alpha_i (alpha_in_i),
    .stall_o (in_stall_o),
    .valid_o (valid[0]),
    .work_o  (work[0]),
    .stall_i (stall[0])
  );

  // row of divider cells
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rhsl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .work_i  (work[i]),
      .stall_o (stall[i]),
      .valid_o (valid[i+1]),
      .work_o  (work[i+1]),
      .stall_i (stall[i+1])
    );
  end

  // result register
  rhsl_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[NumCells]),
    .work_i  (work[NumCells]),
    .stall_o (stall[NumCells]),
    .valid_o (out_valid_o),
    .hue_o   (hue_out_o),
    .sat_o   (sat_out_o),
    .light_o (light_sum_o),
    .alpha_o (alpha_out_o),
    .stall_i (out_stall_i)
  );

endmodule

// ===== design/rhsl_checker.sv =====
// port-level checks for the rgb to hsl converter, bound to the top level
module rhsl_checker import rhsl_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [ChanW-1:0] red_in_i,
  input logic [ChanW-1:0] green_in_i,
  input logic [ChanW-1:0] blue_in_i,
  input logic [ChanW-1:0] alpha_in_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [HueW-1:0]  hue_out_o,
  input logic [ChanW-1:0] sat_out_o,
  input logic [SumW-1:0]  light_sum_o,
  input logic [ChanW-1:0] alpha_out_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hue_out_o)
      && $stable(sat_out_o) && $stable(light_sum_o) && $stable(alpha_out_o))
    else $error("stalled result changed");

  // hue stays below a full turn
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hue_out_o < HueFull)
    else $error("hue out of range");

  // nonzero saturation needs a sum that is neither black nor white
  a_sat_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sat_out_o != '0 |-> light_sum_o != '0 && light_sum_o != SumMax)
    else $error("saturation on black or white");

  // input backs up only behind a waiting result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no waiting result");

endmodule

bind rgb_to_hsl_converter_core rhsl_checker u_rhsl_checker (.*);
